// ===== hw/rtl/sha_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 engine.
// No dependencies.
package sha_pkg;

    localparam int DigestWords = 8;

    localparam logic [7:0] PadByte = 8'h80;

    // Datapath commands from the controller
    typedef struct packed {
        logic store_byte;    // write s_ byte at fill position
        logic count_byte;    // advance byte count
        logic store_pad;     // write a padding byte at pad_pos
        logic pad_mark;      // padding byte is the 0x80 end mark
        logic pad_len;       // padding byte is a bit length byte
        logic load_block;    // chain into working vars, restart round count
        logic do_round;      // one compression round
        logic fold;          // add working vars into chain
        logic reinit;        // restore initial hash, clear count
        logic [5:0] pad_pos; // position for pad write
    } sha_cmd_t;

    typedef struct packed {
        logic [5:0] fill_pos; // byte_count mod 64
        logic [5:0] round;    // current round index
    } sha_stat_t;

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] v;
        case (i)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3a1, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== hw/rtl/sha_datapath.sv =====
// SHA-256 datapath: byte counter, message schedule (which also gathers the
// block bytes), working variables and chaining hash. Depends on sha_pkg.
module sha_datapath import sha_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  sha_cmd_t    cmd,
    input  logic [7:0]  in_byte,
    input  logic [2:0]  rd_index,
    output sha_stat_t   stat,
    output logic [31:0] rd_word
);

    logic [60:0] count_reg;
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];
    logic [5:0]  round_reg;

    logic [63:0] bit_len;
    logic [7:0]  pad_val;
    logic        wr_en;
    logic [5:0]  wr_pos;
    logic [7:0]  wr_val;
    logic [31:0] w_new, w_cur, t1, t2, s0, s1, e, a;

    assign stat.fill_pos = count_reg[5:0];
    assign stat.round    = round_reg;
    assign rd_word       = h_reg[rd_index];

    // Pad byte: 0x80 end mark, big-endian bit length byte, or zero
    assign bit_len = {count_reg, 3'b000};
    always_comb begin
        if (cmd.pad_mark) begin
            pad_val = PadByte;
        end else if (cmd.pad_len) begin
            pad_val = bit_len[{~cmd.pad_pos[2:0], 3'b000} +: 8];
        end else begin
            pad_val = 8'h00;
        end
    end

    // Byte write into the schedule words, first byte in the top lane
    assign wr_en  = cmd.store_byte || cmd.store_pad;
    assign wr_pos = cmd.store_byte ? count_reg[5:0] : cmd.pad_pos;
    assign wr_val = cmd.store_byte ? in_byte : pad_val;

    // Byte counter, modulo 2^61
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.reinit) begin
            count_reg <= '0;
        end else if (cmd.count_byte) begin
            count_reg <= count_reg + 61'd1;
        end
    end

    // Round arithmetic; schedule window shifts so w_reg[0] is W[t]
    always_comb begin
        s0    = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        w_cur = w_reg[0];
        a     = v_reg[0];
        e     = v_reg[4];
        t1 = v_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
             ((e & v_reg[5]) ^ (~e & v_reg[6])) + RoundK[round_reg] + w_cur;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
             ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // Schedule window: byte fill between compressions, shift during rounds
    always_ff @(posedge aclk) begin
        if (cmd.do_round) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
        end else if (wr_en) begin
            w_reg[wr_pos[5:2]][{~wr_pos[1:0], 3'b000} +: 8] <= wr_val;
        end
    end

    // Working variables
    always_ff @(posedge aclk) begin
        if (cmd.load_block) begin
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= h_reg[i];
            end
        end else if (cmd.do_round) begin
            v_reg[7]  <= v_reg[6];
            v_reg[6]  <= v_reg[5];
            v_reg[5]  <= v_reg[4];
            v_reg[4]  <= v_reg[3] + t1;
            v_reg[3]  <= v_reg[2];
            v_reg[2]  <= v_reg[1];
            v_reg[1]  <= v_reg[0];
            v_reg[0]  <= t1 + t2;
        end
    end

    // Round counter
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.load_block) begin
            round_reg <= '0;
        end else if (cmd.do_round) begin
            round_reg <= round_reg + 6'd1;
        end
    end

    // Chaining hash
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.reinit) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= init_hash(3'(i));
            end
        end else if (cmd.fold) begin
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

endmodule

// ===== hw/rtl/sha_ctrl.sv =====
// SHA-256 controller: input handshake, padding sequence, compression
// sequencing and digest output. Depends on sha_pkg.
module sha_ctrl import sha_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,
    input  sha_stat_t   stat,
    output sha_cmd_t    cmd,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  out_index
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_ROUND = 7'b0000100,
        ST_FOLD  = 7'b0001000,
        ST_PAD   = 7'b0010000,
        ST_OUT   = 7'b0100000,
        ST_FILL  = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic       final_reg, final_next;     // current compression is the last one
    logic       padding_reg, padding_next; // end mark still to be written
    logic       tail_reg, tail_next;       // a length-only block follows
    logic [5:0] pos_reg, pos_next;
    logic [2:0] idx_reg, idx_next;
    logic       acc;
    logic       len_blk;

    assign s_tready  = (state_reg == ST_IDLE);
    assign acc       = s_tvalid && s_tready;
    assign m_tvalid  = (state_reg == ST_OUT);
    assign out_index = idx_reg;
    // block being padded carries the bit length
    assign len_blk   = tail_reg || (stat.fill_pos < 6'd56);

    always_comb begin
        state_next   = state_reg;
        final_next   = final_reg;
        padding_next = padding_reg;
        tail_next    = tail_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.pad_pos  = pos_reg;
        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    cmd.store_byte = s_tuser[0];
                    cmd.count_byte = s_tuser[0];
                    if (s_tuser[0] && stat.fill_pos == 6'd63) begin
                        padding_next = s_tuser[1];
                        state_next   = ST_LOAD;
                    end else if (s_tuser[1]) begin
                        state_next = ST_FILL;
                    end
                end
            end
            ST_LOAD: begin
                cmd.load_block = 1'b1;
                state_next     = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.do_round = 1'b1;
                if (stat.round == 6'd63) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                cmd.fold = 1'b1;
                if (final_reg) begin
                    final_next = 1'b0;
                    idx_next   = '0;
                    state_next = ST_OUT;
                end else if (padding_reg) begin
                    state_next = ST_FILL;
                end else if (tail_reg) begin
                    pos_next   = '0;
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FILL: begin
                // write the 0x80 mark at the current fill position
                cmd.store_pad = 1'b1;
                cmd.pad_mark  = 1'b1;
                cmd.pad_pos   = stat.fill_pos;
                padding_next  = 1'b0;
                if (stat.fill_pos == 6'd63) begin
                    tail_next  = 1'b1;
                    state_next = ST_LOAD;
                end else begin
                    pos_next   = stat.fill_pos + 6'd1;
                    state_next = ST_PAD;
                end
            end
            ST_PAD: begin
                // zero fill up to the block end; length bytes only in the last block
                cmd.store_pad = 1'b1;
                cmd.pad_len   = len_blk && (pos_reg >= 6'd56);
                pos_next      = pos_reg + 6'd1;
                if (pos_reg == 6'd63) begin
                    state_next = ST_LOAD;
                    if (len_blk) begin
                        final_next = 1'b1;
                        tail_next  = 1'b0;
                    end else begin
                        tail_next  = 1'b1;
                    end
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'(DigestWords - 1)) begin
                        cmd.reinit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            final_reg   <= 1'b0;
            padding_reg <= 1'b0;
            tail_reg    <= 1'b0;
            pos_reg     <= '0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            final_reg   <= final_next;
            padding_reg <= padding_next;
            tail_reg    <= tail_next;
            pos_reg     <= pos_next;
            idx_reg     <= idx_next;
        end
    end

endmodule

// ===== hw/rtl/sha256_hash_engine.sv =====
// SHA-256 digest engine taking one message byte per item. A byte that closes a
// block is followed by a compression (load, 64 rounds at one per cycle, fold)
// before the next item is taken. The end mark writes the 0x80 mark and the zero
// and length fill one byte per cycle, plus one or two compressions, then eight
// digest items, first word first. Sustained throughput is set by the single
// round unit. Only one item is in work at a time.
module sha256_hash_engine import sha_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] msg_byte
    input  logic [1:0]  s_tuser,   // [0] byte_valid, [1] end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);

    sha_cmd_t  cmd;
    sha_stat_t stat;
    logic [2:0] idx;

    sha_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tuser,
        .stat, .cmd, .m_tvalid, .m_tready, .out_index(idx)
    );

    sha_datapath u_dp (
        .aclk, .aresetn, .cmd, .in_byte(s_tdata), .rd_index(idx),
        .stat, .rd_word(m_tdata)
    );

    assign m_tuser = idx;
    assign m_tlast = (idx == 3'(DigestWords - 1));

endmodule

// ===== hw/rtl/sha_checker.sv =====
// Port-level checks for the SHA-256 engine, bound to the top level.
// Depends on sha256_hash_engine.
module sha_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);
    // no input taken while the digest is shown
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input ready during output");
    // word index advances by one on each taken word
    a_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser == $past(m_tuser) + 3'd1))
        else $error("word index skipped");
    // last flag only on word seven
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == 3'd7))) else $error("last flag wrong");
    // after the last word the engine is ready again
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("not idle after digest");
endmodule

bind sha256_hash_engine sha_checker u_sha_checker (
    .aclk, .aresetn, .s_tready, .m_tvalid, .m_tready, .m_tuser, .m_tlast
);
